FILE: rtl/fbab_pkg.sv
package fbab_pkg;

    // Store geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 16;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Linear index before the range check, and the pixel count of the area
    localparam int IDX_W  = 2 * CFG_W + 1;
    localparam int AREA_W = 2 * CFG_W;

    // Blend sum: up to 255 * 255
    localparam int SUM_W = 2 * CH_W + 1;

    localparam int VIS_RESET = 256;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BLEND = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIS_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] t_pixel;

endpackage

FILE: rtl/fbab_in_if.sv
interface fbab_in_if;
    import fbab_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [CH_W-1:0]          alpha;
    logic [CH_W-1:0]          red;
    logic [CH_W-1:0]          green;
    logic [CH_W-1:0]          blue;

    modport source (
        output valid, func, pos_x, pos_y, alpha, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, func, pos_x, pos_y, alpha, red, green, blue,
        output ready
    );

endinterface

FILE: rtl/fbab_out_if.sv
interface fbab_out_if;
    import fbab_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] read_red;
    logic [CH_W-1:0] read_green;
    logic [CH_W-1:0] read_blue;
    logic            inside_area;

    modport source (
        output valid, read_red, read_green, read_blue, inside_area,
        input  ready
    );

    modport sink (
        input  valid, read_red, read_green, read_blue, inside_area,
        output ready
    );

endinterface

FILE: rtl/fbab_ram.sv
module fbab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/framebuffer_alpha_blend_pixel_engine.sv
// Channel   Dir  Handshake         Payload
// i_pix     in   valid / ready     func, pos_x, pos_y, alpha, red, green, blue
// o_rd      out  valid / ready     read_red, read_green, read_blue, inside_area
// i_cfg_*   in   write enable      i_cfg_idx selects width or height, i_cfg_data
//
// One item at a time through the pixel RAM, whose read data is registered: a write goes
// IDLE, EXEC; a read IDLE, EXEC, DATA; a blend IDLE, EXEC, DATA, MIX; a clear sweeps in CLEAR.
// The read and the read-modify-write of a blend occupy the RAM in turn, never together.
// Reset: width and height go to 256; pixel contents are undefined until written.
// A read result waits in the output register; a new item is taken meanwhile, and a
// later read holds in its final state until the output register is free.
module framebuffer_alpha_blend_pixel_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fbab_in_if.sink                         i_pix,
    fbab_out_if.source                      o_rd,
    input  logic                            i_cfg_we,
    input  logic [fbab_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbab_pkg::CFG_W-1:0]      i_cfg_data
);
    import fbab_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DATA  = 3'd2;
    localparam logic [2:0] S_MIX   = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    // Configuration
    logic [CFG_W-1:0]   r_vis_w;
    logic [CFG_W-1:0]   r_vis_h;
    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;

    // Control
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [AREA_W-1:0]  r_cnt;
    logic [AREA_W-1:0]  n_cnt;
    logic [AREA_W-1:0]  r_area;
    logic [AREA_W-1:0]  n_area;

    // Captured item
    logic [FUNC_W-1:0]  r_op;
    logic               r_inside;
    logic [ADDR_W-1:0]  r_idx;
    logic [CH_W-1:0]    r_alpha;
    t_pixel             r_col;

    // Blend lanes
    logic [SUM_W-1:0]   r_sum [NUM_CH];
    logic [SUM_W-1:0]   n_sum [NUM_CH];
    t_pixel             mix_pix;

    // Output register
    logic               r_out_valid;
    logic               n_out_valid;
    t_pixel             r_out_pix;
    t_pixel             n_out_pix;
    logic               r_out_inside;
    logic               n_out_inside;
    logic               out_free;

    // Address decode of the incoming item
    logic                   in_xfer;
    logic                   x_ok;
    logic                   y_ok;
    logic [2*CFG_W-1:0]     row_base;
    logic [IDX_W-1:0]       lin_idx;
    logic                   in_inside;
    logic [AREA_W-1:0]      area_raw;
    logic [AREA_W-1:0]      area_cap;

    // RAM port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_pixel             ram_wdata;
    logic               ram_re;
    t_pixel             ram_rdata;

    // Saturate the visible area to the store size
    assign w_eff = (int'(r_vis_w) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : r_vis_w;
    assign h_eff = (int'(r_vis_h) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : r_vis_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_w <= CFG_W'(VIS_RESET);
            r_vis_h <= CFG_W'(VIS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VIS_WIDTH:  r_vis_w <= i_cfg_data;
                REG_VIS_HEIGHT: r_vis_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign in_xfer     = i_pix.valid && i_pix.ready;

    // Clip, then form y * width + x; y fits CFG_W bits whenever it is in range
    assign x_ok = !i_pix.pos_x[POS_W-1] && ($unsigned(i_pix.pos_x) < POS_W'(w_eff));
    assign y_ok = !i_pix.pos_y[POS_W-1] && ($unsigned(i_pix.pos_y) < POS_W'(h_eff));
    assign row_base  = i_pix.pos_y[CFG_W-1:0] * w_eff;
    assign lin_idx   = IDX_W'(row_base) + IDX_W'(i_pix.pos_x[CFG_W-1:0]);
    assign in_inside = x_ok && y_ok && (lin_idx < STORE_DEPTH);

    // Pixel count for a clear, capped to the store
    assign area_raw = w_eff * h_eff;
    assign area_cap = (area_raw > STORE_DEPTH) ? AREA_W'(STORE_DEPTH) : area_raw;

    assign out_free = !r_out_valid || o_rd.ready;

    // Blend: 255*old + alpha*(new - old), one multiplier per channel
    always_comb begin
        logic [CH_W-1:0]            old_c;
        logic [CH_W-1:0]            new_c;
        logic signed [CH_W:0]       diff;
        logic signed [CH_W:0]       a_s;
        logic signed [2*CH_W+1:0]   prod;
        logic signed [2*CH_W+1:0]   total;
        for (int c = 0; c < NUM_CH; c++) begin
            old_c = ram_rdata[c*CH_W +: CH_W];
            new_c = r_col[c*CH_W +: CH_W];
            diff  = $signed({1'b0, new_c}) - $signed({1'b0, old_c});
            a_s   = $signed({1'b0, r_alpha});
            prod  = (2*CH_W+2)'(diff * a_s);
            total = $signed({2'b00, old_c, {CH_W{1'b0}}})
                  - $signed({{(CH_W+2){1'b0}}, old_c}) + prod;
            n_sum[c] = total[SUM_W-1:0];
        end
    end

    // Divide by 255: exact for every sum up to 255 * 255
    always_comb begin
        logic [SUM_W-1:0] q;
        for (int c = 0; c < NUM_CH; c++) begin
            q = (r_sum[c] + (r_sum[c] >> CH_W) + SUM_W'(1)) >> CH_W;
            mix_pix[c*CH_W +: CH_W] = q[CH_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_area       = r_area;
        n_out_valid  = r_out_valid && !o_rd.ready;
        n_out_pix    = r_out_pix;
        n_out_inside = r_out_inside;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = r_col;
        ram_re       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    FN_CLEAR: begin
                        n_cnt  = '0;
                        n_area = area_cap;
                        n_state = (area_cap == '0) ? S_IDLE : S_CLEAR;
                    end
                    FN_WRITE: begin
                        ram_we  = r_inside;
                        n_state = S_IDLE;
                    end
                    FN_BLEND: begin
                        ram_re  = r_inside;
                        n_state = r_inside ? S_DATA : S_IDLE;
                    end
                    FN_READ: begin
                        if (r_inside) begin
                            ram_re  = 1'b1;
                            n_state = S_DATA;
                        end else if (out_free) begin
                            // outside the area: answer zeros
                            n_out_valid  = 1'b1;
                            n_out_pix    = '0;
                            n_out_inside = 1'b0;
                            n_state      = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DATA: begin
                if (r_op == FN_BLEND) begin
                    n_state = S_MIX;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pix    = ram_rdata;
                    n_out_inside = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MIX: begin
                ram_we    = 1'b1;
                ram_wdata = mix_pix;
                n_state   = S_IDLE;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_cnt);
                n_cnt     = r_cnt + AREA_W'(1);
                if (r_cnt == r_area - AREA_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_area      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_area      <= n_area;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: capture the item, the blend sums and the result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= i_pix.func;
            r_inside <= in_inside;
            r_idx    <= ADDR_W'(lin_idx);
            r_alpha  <= i_pix.alpha;
            r_col    <= {i_pix.red, i_pix.green, i_pix.blue};
        end
        if (r_state == S_DATA) begin
            r_sum <= n_sum;
        end
        r_out_pix    <= n_out_pix;
        r_out_inside <= n_out_inside;
    end

    fbab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_rd.valid       = r_out_valid;
    assign o_rd.read_red    = r_out_pix[2*CH_W +: CH_W];
    assign o_rd.read_green  = r_out_pix[CH_W +: CH_W];
    assign o_rd.read_blue   = r_out_pix[0 +: CH_W];
    assign o_rd.inside_area = r_out_inside;

    // The pixel RAM is never read and written together
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("pixel RAM read and write in one cycle");

    // An accepted transfer is always dispatched next
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EXEC))
        else $error("accepted item not dispatched");

    // The clear sweep stays within the visible pixel count
    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_cnt < r_area))
        else $error("clear sweep out of range");

    // Single-pixel writes only land inside the visible area
    a_write_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_EXEC || r_state == S_MIX)) |-> r_inside)
        else $error("write outside the visible area");

    // Only a read produces a result
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_op == FN_READ))
        else $error("result from a non-read operation");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import fbab_pkg::*;

    // Cycles with no transfer on either channel before the run is abandoned. A clear of
    // the full 256 x 256 area alone holds the input for its whole sweep of the store.
    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [CH_W-1:0]         alpha;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
    } t_pix_op;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            in_area;
    } t_read_px;

    // Clock, reset and every driven input start from known values
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               pix_valid = 1'b0;
    t_pix_op            cur_op    = '0;
    logic               rd_ready  = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_VIS_WIDTH;
    logic [CFG_W-1:0]   cfg_data  = '0;

    fbab_in_if  pix_if ();
    fbab_out_if rd_if ();

    assign pix_if.valid = pix_valid;
    assign pix_if.func  = cur_op.func;
    assign pix_if.pos_x = cur_op.pos_x;
    assign pix_if.pos_y = cur_op.pos_y;
    assign pix_if.alpha = cur_op.alpha;
    assign pix_if.red   = cur_op.red;
    assign pix_if.green = cur_op.green;
    assign pix_if.blue  = cur_op.blue;
    assign rd_if.ready  = rd_ready;

    framebuffer_alpha_blend_pixel_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_rd       (rd_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow framebuffer and its own copy of the area registers
    t_pixel      shadow_fb [STORE_DEPTH];
    int unsigned area_w_reg = VIS_RESET;
    int unsigned area_h_reg = VIS_RESET;

    t_pix_op  pending_ops[$];
    t_read_px read_expect_q[$];

    // Area as the generator sees it, already saturated
    int gen_w = VIS_RESET;
    int gen_h = VIS_RESET;

    int mismatches     = 0;
    int ops_taken      = 0;
    int reads_checked  = 0;
    int area_settings  = 1;
    int quiet_cycles   = 0;
    int pix_gap        = 0;
    int gap_now;
    int rd_stall       = 0;
    int stall_now;

    function automatic int clamp_dim(int unsigned reg_val, int cap);
        return (reg_val > cap) ? cap : int'(reg_val);
    endfunction

    // Linear index of (x, y) when it lies inside a w x h area
    function automatic bit pixel_index(input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] y,
                                       input int w, input int h, output int idx);
        int sx;
        int sy;
        sx  = x;
        sy  = y;
        idx = 0;
        if (sx < 0 || sy < 0 || sx >= w || sy >= h)
            return 1'b0;
        idx = sy * w + sx;
        return idx < STORE_DEPTH;
    endfunction

    function automatic logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] old_ch,
                                                      logic [CH_W-1:0] new_ch,
                                                      logic [CH_W-1:0] a);
        int unsigned mixed;
        mixed = (255 - a) * old_ch + a * new_ch;
        return CH_W'(mixed / 255);
    endfunction

    // Update the shadow framebuffer with one transferred item; queue the answer of a read
    function automatic void apply_pixel_op(t_pix_op op);
        int       w;
        int       h;
        int       idx;
        bit       hit;
        t_pixel   old_px;
        t_read_px ans;
        w   = clamp_dim(area_w_reg, MAX_WIDTH);
        h   = clamp_dim(area_h_reg, MAX_HEIGHT);
        hit = pixel_index(op.pos_x, op.pos_y, w, h, idx);
        case (op.func)
            FN_CLEAR: begin
                // position and alpha play no part in a clear
                for (int i = 0; i < w * h; i++)
                    shadow_fb[i] = {op.red, op.green, op.blue};
            end
            FN_WRITE: begin
                if (hit)
                    shadow_fb[idx] = {op.red, op.green, op.blue};
            end
            FN_BLEND: begin
                if (hit) begin
                    old_px = shadow_fb[idx];
                    shadow_fb[idx] = {blend_channel(old_px[23:16], op.red, op.alpha),
                                      blend_channel(old_px[15:8], op.green, op.alpha),
                                      blend_channel(old_px[7:0], op.blue, op.alpha)};
                end
            end
            default: begin
                if (hit)
                    ans = {shadow_fb[idx], 1'b1};
                else
                    ans = '0;
                read_expect_q.push_back(ans);
            end
        endcase
    endfunction

    // Every third stretch of items (32 on the input side, 16 on the result side) runs with no idling at all
    function automatic int draw_wait(int count, int stretch);
        if ((count / stretch) % 3 == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic flag_mismatch(string field, logic [CH_W-1:0] got, logic [CH_W-1:0] want);
        $display("mismatch on %s at read %0d: got %h, want %h",
                 field, reads_checked, got, want);
        mismatches++;
    endtask

    // Input side: hold an item until its transfer, then wait the drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
            pix_gap   <= 0;
        end else if (!pix_valid || pix_if.ready) begin
            gap_now = pix_gap;
            if (pix_valid) begin
                apply_pixel_op(cur_op);
                ops_taken++;
                gap_now = draw_wait(ops_taken, 32);
            end
            if (gap_now == 0 && pending_ops.size() > 0) begin
                cur_op    <= pending_ops.pop_front();
                pix_valid <= 1'b1;
                pix_gap   <= 0;
            end else begin
                pix_valid <= 1'b0;
                if (gap_now > 0)
                    pix_gap <= gap_now - 1;
            end
        end
    end

    // Result side: compare each transfer with the oldest expected read, then stall a while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ready <= 1'b0;
            rd_stall <= 0;
        end else if (rd_if.valid && rd_ready) begin
            if (read_expect_q.size() == 0) begin
                flag_mismatch("unexpected read", rd_if.read_red, '0);
            end else begin
                t_read_px want;
                want = read_expect_q.pop_front();
                if (rd_if.read_red !== want.red)
                    flag_mismatch("read_red", rd_if.read_red, want.red);
                if (rd_if.read_green !== want.green)
                    flag_mismatch("read_green", rd_if.read_green, want.green);
                if (rd_if.read_blue !== want.blue)
                    flag_mismatch("read_blue", rd_if.read_blue, want.blue);
                if (rd_if.inside_area !== want.in_area)
                    flag_mismatch("inside_area", CH_W'(rd_if.inside_area),
                                  CH_W'(want.in_area));
            end
            reads_checked++;
            stall_now = draw_wait(reads_checked, 16);
            if (stall_now == 0) begin
                rd_ready <= 1'b1;
            end else begin
                rd_ready <= 1'b0;
                rd_stall <= stall_now - 1;
            end
        end else if (rd_stall > 0) begin
            rd_stall <= rd_stall - 1;
        end else begin
            rd_ready <= 1'b1;
        end
    end

    // Abandon the run when nothing has moved on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((pix_valid && pix_if.ready) || (rd_if.valid && rd_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_op(logic [FUNC_W-1:0] fn, int x, int y, int a, int r, int g, int b);
        t_pix_op op;
        op.func  = fn;
        op.pos_x = POS_W'(x);
        op.pos_y = POS_W'(y);
        op.alpha = CH_W'(a);
        op.red   = CH_W'(r);
        op.green = CH_W'(g);
        op.blue  = CH_W'(b);
        pending_ops.push_back(op);
    endtask

    // Mostly positions inside the area, some just past an edge, some anywhere at all
    task automatic add_random_op();
        int pick;
        int x;
        int y;
        int a;
        logic [FUNC_W-1:0] fn;
        pick = $urandom_range(0, 99);
        if (pick < 3 && gen_w * gen_h <= 1024)
            fn = FN_CLEAR;
        else if (pick < 35)
            fn = FN_WRITE;
        else if (pick < 65)
            fn = FN_BLEND;
        else
            fn = FN_READ;
        pick = $urandom_range(0, 9);
        if (pick < 7 && gen_w > 0 && gen_h > 0) begin
            x = $urandom_range(0, gen_w - 1);
            y = $urandom_range(0, gen_h - 1);
        end else if (pick < 9) begin
            x = $urandom_range(0, gen_w);
            y = $urandom_range(0, gen_h);
            case ($urandom_range(0, 3))
                0:       x = -1;
                1:       x = gen_w;
                2:       y = -1;
                default: y = gen_h;
            endcase
        end else begin
            x = int'($urandom);
            y = int'($urandom);
        end
        case ($urandom_range(0, 4))
            0:       a = 0;
            1:       a = 255;
            default: a = $urandom_range(0, 255);
        endcase
        add_op(fn, x, y, a, $urandom, $urandom, $urandom);
    endtask

    // Sample at the falling edge so the driver's updates of this cycle have landed
    task automatic settle_block();
        do
            @(negedge i_clk);
        while (pending_ops.size() != 0 || pix_valid || read_expect_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_area(int w, int h);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_VIS_WIDTH;
        cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        cfg_idx  <= REG_VIS_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        area_w_reg = w;
        area_h_reg = h;
        gen_w = clamp_dim(w, MAX_WIDTH);
        gen_h = clamp_dim(h, MAX_HEIGHT);
        area_settings++;
    endtask

    // One area setting: drain, reprogram, optionally clear, random items, closing read.
    // Ending on a read means its answer proves every earlier item has finished.
    task automatic run_phase(int w, int h, bit with_clear, int n_items);
        settle_block();
        set_area(w, h);
        if (with_clear)
            add_op(FN_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (n_items) add_random_op();
        add_op(FN_READ, 0, 0, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset area of 256 x 256. The clear comes first and covers
        // the whole store, so no later read or blend can meet an unwritten pixel.
        add_op(FN_CLEAR, -5, 7, 9, 'h12, 'h34, 'h56);
        add_op(FN_WRITE, 0, 0, 0, 'hff, 'hff, 'hff);
        add_op(FN_WRITE, 255, 255, 255, 'h00, 'h00, 'h00);
        add_op(FN_WRITE, 255, 0, 17, 'ha5, 'h5a, 'hc3);
        // writes past the edges must be dropped, not wrapped into the next row
        add_op(FN_WRITE, 256, 0, 0, 'h01, 'h02, 'h03);
        add_op(FN_WRITE, -1, 5, 0, 'h04, 'h05, 'h06);
        add_op(FN_WRITE, -32768, 32767, 0, 'h07, 'h08, 'h09);
        add_op(FN_READ, 0, 0, 0, 0, 0, 0);
        add_op(FN_READ, 255, 255, 'hff, 'hff, 'hff, 'hff);
        add_op(FN_READ, 256, 0, 0, 0, 0, 0);
        add_op(FN_READ, 0, -32768, 0, 0, 0, 0);
        add_op(FN_READ, 32767, 0, 0, 0, 0, 0);
        add_op(FN_READ, 0, 1, 0, 0, 0, 0);
        // blends: fully transparent, fully opaque, half way, and one off the area
        add_op(FN_BLEND, 0, 0, 0, 'h00, 'h00, 'h00);
        add_op(FN_BLEND, 255, 255, 255, 'hff, 'h80, 'h01);
        add_op(FN_BLEND, 255, 0, 128, 'h10, 'h20, 'h30);
        add_op(FN_BLEND, -1, -1, 200, 'hff, 'hff, 'hff);
        add_op(FN_READ, 0, 0, 0, 0, 0, 0);
        add_op(FN_READ, 255, 255, 0, 0, 0, 0);
        add_op(FN_READ, 255, 0, 0, 0, 0, 0);
        add_op(FN_READ, 10, 200, 0, 0, 0, 0);
        add_op(FN_WRITE, 100, 100, 'h5c, 'h3c, 'hc3, 'h99);
        add_op(FN_READ, 100, 100, 0, 0, 0, 0);
        repeat (40) add_random_op();
        add_op(FN_READ, 0, 0, 0, 0, 0, 0);

        run_phase(1, 1, 1'b1, 40);
        // empty area: clear does nothing and every access falls outside
        run_phase(0, 37, 1'b1, 30);
        run_phase(12, 0, 1'b1, 20);
        run_phase(16, 9, 1'b1, 60);
        // new stride over the same pixels, no clear in between
        run_phase(9, 16, 1'b0, 60);
        // register values past the maximum saturate to it
        run_phase(511, 300, 1'b1, 50);
        run_phase(256, 1, 1'b0, 50);
        run_phase(1, 256, 1'b0, 50);
        repeat (2) run_phase($urandom_range(1, 24), $urandom_range(1, 24), 1'b1, 50);

        settle_block();
        repeat (16) @(posedge i_clk);
        $display("covered %0d pixel operations over %0d area settings", ops_taken,
                 area_settings);
        $display("compared %0d read results, %0d mismatches", reads_checked, mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: framebuffer_alpha_blend_pixel_engine.f
rtl/fbab_pkg.sv
rtl/fbab_in_if.sv
rtl/fbab_out_if.sv
rtl/fbab_ram.sv
rtl/framebuffer_alpha_blend_pixel_engine.sv
test/tb.sv
